// ===== src/length_prefixed_packet_deframer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed packet deframer
// Clocked property checks on clk, with or without the rst_n qualifier.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
// check while out of reset
`define LPPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on every edge, reset included
`define LPPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPPD_ASSERT(lbl, prop, msg)
`define LPPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/lppd_pkg.sv =====
// ----------------------------------------------------------------------------
// Deframer package
// Shared constants, codes and structs of the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lppd_pkg;

  localparam int unsigned HDR_LEN     = 12;
  localparam int unsigned HDR_CNT_W   = 4;
  localparam int unsigned SHIFT_BYTES = 8;   // header bytes kept in the 64-bit shifter

  localparam logic [HDR_CNT_W-1:0] HDR_LAST  = HDR_CNT_W'(HDR_LEN - 1);
  localparam logic [HDR_CNT_W-1:0] HDR_SPLIT = HDR_CNT_W'(SHIFT_BYTES);

  localparam logic [15:0] VERSION_RST   = 16'd1;
  localparam logic [31:0] MAX_LEN_RST   = 32'(1024 * 1024);
  localparam logic [63:0] TYPE_MASK_RST = 64'd0;

  typedef enum logic [1:0] {
    KIND_BODY   = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_VERSION = 2'd0,
    ERR_TYPE    = 2'd1,
    ERR_LENGTH  = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    REG_VERSION   = 2'd0,
    REG_MAX_LEN   = 2'd1,
    REG_TYPE_MASK = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] expected_version;
    logic [31:0] max_body_length;
    logic [63:0] known_type_mask;
  } cfg_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [15:0] message_type;
    logic [31:0] request_id;
    logic [7:0]  body_byte;
    logic        last_of_packet;
    err_t        error_code;
  } result_t;

endpackage

// ===== src/lppd_if.sv =====
// ----------------------------------------------------------------------------
// Deframer channel interfaces
// Valid/ready channels for the byte input, the result output and config.
// ----------------------------------------------------------------------------
interface lppd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface lppd_out_if;
  logic                valid;
  logic                ready;
  lppd_pkg::kind_t     result_kind;
  logic [15:0]         message_type;
  logic [31:0]         request_id;
  logic [7:0]          body_byte;
  logic                last_of_packet;
  lppd_pkg::err_t      error_code;

  modport source (output valid, output result_kind, output message_type,
                  output request_id, output body_byte, output last_of_packet,
                  output error_code, input ready);
  modport sink   (input valid, input result_kind, input message_type,
                  input request_id, input body_byte, input last_of_packet,
                  input error_code, output ready);
endinterface

interface lppd_cfg_if;
  logic                valid;
  logic                ready;
  lppd_pkg::reg_idx_t  index;
  logic [63:0]         data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/lppd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Deframer configuration registers
// Version, maximum body length and known-type mask, written by index.
// ----------------------------------------------------------------------------
module lppd_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  lppd_pkg::reg_idx_t  wr_index,
  input  logic [63:0]         wr_data,
  output lppd_pkg::cfg_t      cfg
);
  import lppd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_VERSION:   cfg_nxt.expected_version = wr_data[15:0];
        REG_MAX_LEN:   cfg_nxt.max_body_length  = wr_data[31:0];
        REG_TYPE_MASK: cfg_nxt.known_type_mask  = wr_data;
        default:       cfg_nxt = cfg_r;  // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_version <= VERSION_RST;
      cfg_r.max_body_length  <= MAX_LEN_RST;
      cfg_r.known_type_mask  <= TYPE_MASK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/lppd_core.sv =====
// ----------------------------------------------------------------------------
// Deframer core
// Input beat register, header collection, header checks and body tagging.
// ----------------------------------------------------------------------------
`include "length_prefixed_packet_deframer_assert.svh"

module lppd_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  output logic               in_ready,
  input  lppd_pkg::cfg_t     cfg,
  input  logic               out_free,
  output logic               res_valid,
  output lppd_pkg::result_t  res
);
  import lppd_pkg::*;

  logic                 s1_valid_r, s1_valid_nxt;
  logic [7:0]           s1_byte_r;
  logic                 s1_adv;

  logic                 in_body_r, in_body_nxt;
  logic [HDR_CNT_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [63:0]          hdr_r, hdr_nxt;
  logic [31:0]          rid_r, rid_nxt;
  logic [15:0]          type_r, type_nxt;
  logic [31:0]          remain_r, remain_nxt;

  logic                 emit;
  logic                 body_last;
  logic [31:0]          rid_full;
  logic [15:0]          h_type;
  logic [15:0]          h_ver;
  logic [31:0]          h_len;
  logic                 type_known;

  // advance unless a result is due and the result register is still full
  assign s1_adv       = s1_valid_r && (!emit || out_free);
  assign in_ready     = !s1_valid_r || s1_adv;
  assign s1_valid_nxt = (in_valid && in_ready) || (s1_valid_r && !s1_adv);
  assign res_valid    = emit && s1_adv;

  assign body_last  = (remain_r <= 32'd1);
  assign rid_full   = {rid_r[23:0], s1_byte_r};
  assign h_type     = hdr_r[63:48];
  assign h_ver      = hdr_r[47:32];
  assign h_len      = hdr_r[31:0];
  assign type_known = (h_type[15:6] == 10'd0) && cfg.known_type_mask[h_type[5:0]];

  always_comb begin
    in_body_nxt = in_body_r;
    hdr_cnt_nxt = hdr_cnt_r;
    hdr_nxt     = hdr_r;
    rid_nxt     = rid_r;
    type_nxt    = type_r;
    remain_nxt  = remain_r;
    emit        = 1'b0;
    res         = '0;
    // error code field reads zero unless a check fails
    res.error_code = ERR_VERSION;

    if (in_body_r) begin
      emit               = 1'b1;
      res.result_kind    = KIND_BODY;
      res.message_type   = type_r;
      res.request_id     = rid_r;
      res.body_byte      = s1_byte_r;
      res.last_of_packet = body_last;
      remain_nxt         = remain_r - 32'd1;
      if (body_last) begin
        remain_nxt  = '0;
        in_body_nxt = 1'b0;
      end
    end else if (hdr_cnt_r == HDR_LAST) begin
      emit             = 1'b1;
      hdr_cnt_nxt      = '0;
      rid_nxt          = rid_full;
      res.message_type = h_type;
      res.request_id   = rid_full;
      if (h_ver != cfg.expected_version) begin
        res.result_kind = KIND_REJECT;
        res.error_code  = ERR_VERSION;
      end else if (!type_known) begin
        res.result_kind = KIND_REJECT;
        res.error_code  = ERR_TYPE;
      end else if (h_len > cfg.max_body_length) begin
        res.result_kind = KIND_REJECT;
        res.error_code  = ERR_LENGTH;
      end else if (h_len == 32'd0) begin
        type_nxt           = h_type;
        res.result_kind    = KIND_EMPTY;
        res.last_of_packet = 1'b1;
      end else begin
        // accepted header with a body: hold the tags, no result on this beat
        emit        = 1'b0;
        type_nxt    = h_type;
        in_body_nxt = 1'b1;
        remain_nxt  = h_len;
      end
    end else begin
      hdr_cnt_nxt = hdr_cnt_r + HDR_CNT_W'(1);
      if (hdr_cnt_r < HDR_SPLIT) begin
        hdr_nxt = {hdr_r[55:0], s1_byte_r};
      end else begin
        rid_nxt = rid_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      in_body_r  <= 1'b0;
      hdr_cnt_r  <= '0;
      hdr_r      <= '0;
      rid_r      <= '0;
      type_r     <= '0;
      remain_r   <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_adv) begin
        in_body_r <= in_body_nxt;
        hdr_cnt_r <= hdr_cnt_nxt;
        hdr_r     <= hdr_nxt;
        rid_r     <= rid_nxt;
        type_r    <= type_nxt;
        remain_r  <= remain_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
    end
  end

  `LPPD_ASSERT(a_body_state, in_body_r |-> (hdr_cnt_r == '0 && remain_r != '0), "body state with header count or zero remaining")
  `LPPD_ASSERT(a_hdr_cnt_range, !(hdr_cnt_r > HDR_LAST), "header count past header end")
  `LPPD_ASSERT(a_last_ends_body, (s1_adv && in_body_r && body_last) |=> !in_body_r, "body continues after last byte")
  `LPPD_ASSERT(a_res_slot_free, res_valid |-> out_free, "result issued into a full result register")
  `LPPD_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (!in_body_r && hdr_cnt_r == '0 && !s1_valid_r), "reset left the core busy")

endmodule

// ===== src/lppd_out_reg.sv =====
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module lppd_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  lppd_pkg::result_t  res,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_ready,
  output lppd_pkg::result_t  out_res
);
  import lppd_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  assign out_free      = !out_valid_r || out_ready;
  assign out_valid_nxt = res_valid || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== src/length_prefixed_packet_deframer.sv =====
// Path: an accepted byte waits in the input beat register, and its result is registered in the result register.
// Throughput: one byte per cycle; the input register and the result register keep
// both sides moving, a result waiting on out_ch stalls input only once both are full.
// Reset: rst_n is synchronous and active low; config returns to its defaults,
// the deframer restarts at header byte 0, and there is no clearing pass.
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer
// Splits a byte stream into checked 12-byte headers and tagged body bytes.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  lppd_in_if.sink     in_ch,
  lppd_out_if.source  out_ch,
  lppd_cfg_if.sink    cfg_ch
);
  import lppd_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_res;
  logic    res_valid;
  logic    out_free;

  assign cfg_ch.ready = 1'b1;

  lppd_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  lppd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_byte   (in_ch.data_byte),
    .in_ready  (in_ch.ready),
    .cfg       (cfg),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  lppd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.result_kind    = out_res.result_kind;
  assign out_ch.message_type   = out_res.message_type;
  assign out_ch.request_id     = out_res.request_id;
  assign out_ch.body_byte      = out_res.body_byte;
  assign out_ch.last_of_packet = out_res.last_of_packet;
  assign out_ch.error_code     = out_res.error_code;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer testbench
// Feeds whole headers, bodies, rejected headers and stray bytes through the
// byte channel under several register settings and idle patterns, predicts
// every result from a cycle-free model of the framing, and checks each
// result beat in order.
// ----------------------------------------------------------------------------
module testbench;
  import lppd_pkg::*;

  class deframe_predictor;
    logic [15:0] exp_version;
    logic [31:0] max_len;
    logic [63:0] type_mask;
    bit          in_body;
    int unsigned hdr_count;
    logic [63:0] hdr_shift;
    logic [31:0] req_id;
    logic [15:0] cur_type;
    logic [31:0] remaining;
    result_t     pending_results[$];
    int unsigned mismatch_count;

    function new();
      exp_version    = VERSION_RST;
      max_len        = MAX_LEN_RST;
      type_mask      = TYPE_MASK_RST;
      in_body        = 1'b0;
      hdr_count      = 0;
      hdr_shift      = '0;
      req_id         = '0;
      cur_type       = '0;
      remaining      = '0;
      mismatch_count = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [63:0] value);
      case (idx)
        REG_VERSION:   exp_version = value[15:0];
        REG_MAX_LEN:   max_len     = value[31:0];
        REG_TYPE_MASK: type_mask   = value;
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b);
      result_t     r;
      logic [15:0] typ;
      logic [15:0] ver;
      logic [31:0] len;
      bit          known;
      r = '0;
      if (in_body) begin
        r.result_kind    = KIND_BODY;
        r.message_type   = cur_type;
        r.request_id     = req_id;
        r.body_byte      = b;
        r.last_of_packet = (remaining <= 1);
        r.error_code     = ERR_VERSION;
        pending_results.push_back(r);
        if (remaining <= 1) begin
          remaining = '0;
          in_body   = 1'b0;
        end else begin
          remaining = remaining - 1;
        end
        return;
      end
      if (hdr_count < SHIFT_BYTES) hdr_shift = {hdr_shift[55:0], b};
      else req_id = {req_id[23:0], b};
      hdr_count++;
      if (hdr_count < HDR_LEN) return;

      hdr_count = 0;
      typ       = hdr_shift[63:48];
      ver       = hdr_shift[47:32];
      len       = hdr_shift[31:0];
      hdr_shift = '0;
      known     = (typ < 64) && type_mask[typ[5:0]];
      r.message_type = typ;
      r.request_id   = req_id;
      r.result_kind  = KIND_REJECT;
      // first failing check wins
      if (ver != exp_version) begin
        r.error_code = ERR_VERSION;
        pending_results.push_back(r);
      end else if (!known) begin
        r.error_code = ERR_TYPE;
        pending_results.push_back(r);
      end else if (len > max_len) begin
        r.error_code = ERR_LENGTH;
        pending_results.push_back(r);
      end else begin
        cur_type = typ;
        if (len == 0) begin
          r.result_kind    = KIND_EMPTY;
          r.last_of_packet = 1'b1;
          r.error_code     = ERR_VERSION;
          pending_results.push_back(r);
        end else begin
          in_body   = 1'b1;
          remaining = len;
        end
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      bit      bad;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: kind %0d type %h id %h byte %h last %b err %0d",
                   got.result_kind, got.message_type, got.request_id, got.body_byte,
                   got.last_of_packet, got.error_code);
        return;
      end
      want = pending_results.pop_front();
      bad = (got.result_kind !== want.result_kind) ||
            (got.message_type !== want.message_type) ||
            (got.request_id !== want.request_id) ||
            (got.body_byte !== want.body_byte) ||
            (got.last_of_packet !== want.last_of_packet) ||
            (got.error_code !== want.error_code);
      if (bad) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("mismatch: expected kind %0d type %h id %h byte %h last %b err %0d",
                   want.result_kind, want.message_type, want.request_id, want.body_byte,
                   want.last_of_packet, want.error_code);
          $display("          actual   kind %0d type %h id %h byte %h last %b err %0d",
                   got.result_kind, got.message_type, got.request_id, got.body_byte,
                   got.last_of_packet, got.error_code);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  lppd_in_if  in_ch ();
  lppd_out_if out_ch ();
  lppd_cfg_if cfg_ch ();

  length_prefixed_packet_deframer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  deframe_predictor pred;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;
  int unsigned      sent_bytes;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** length_prefixed_packet_deframer: FAILED **");
    $finish;
  end

  // receiver: stall at random per phase
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      pred.check_result({out_ch.result_kind, out_ch.message_type, out_ch.request_id,
                         out_ch.body_byte, out_ch.last_of_packet, out_ch.error_code});
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.data_byte = b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pred.take_byte(b);
    sent_bytes++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pred.pending_results.size() != 0) @(posedge clk);
    // let header bytes still inside the pipeline settle
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    pred.write_reg(idx, value);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // header, then body bytes while the predictor says a body is passing
  task automatic send_packet(input logic [15:0] typ, input logic [15:0] ver,
                             input logic [31:0] len, input logic [31:0] id);
    logic [95:0] hdr;
    int unsigned n;
    hdr = {typ, ver, len, id};
    for (int i = 11; i >= 0; i--) send_byte(hdr[i*8 +: 8]);
    n = 0;
    while (pred.in_body && n < 64) begin
      send_byte(8'($urandom));
      n++;
    end
  endtask

  // stray bytes, then complete whatever header and body they started
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 11);
    repeat (n) send_byte(8'($urandom));
    n = 0;
    while ((pred.hdr_count != 0 || pred.in_body) && n < 64) begin
      send_byte(8'($urandom));
      n++;
    end
  endtask

  function automatic logic [15:0] known_type(logic [63:0] mask);
    int unsigned t;
    if (mask == '0) return 16'($urandom_range(63));
    repeat (200) begin
      t = $urandom_range(63);
      if (mask[t]) return 16'(t);
    end
    for (int i = 0; i < 64; i++) if (mask[i]) return 16'(i);
    return 16'd0;
  endfunction

  task automatic random_item();
    int unsigned sel;
    logic [15:0] typ;
    logic [15:0] ver;
    logic [31:0] len;
    logic [31:0] cap;
    sel = $urandom_range(99);
    typ = known_type(pred.type_mask);
    ver = pred.exp_version;
    cap = (pred.max_len < 12) ? pred.max_len : 32'd12;
    len = $urandom_range(0, cap);
    if ($urandom_range(19) == 0)
      len = $urandom_range(0, (pred.max_len < 40) ? pred.max_len : 32'd40);
    if (sel < 75) begin
      send_packet(typ, ver, len, $urandom);
    end else if (sel < 88) begin
      case ($urandom_range(3))
        0: ver = ver ^ 16'($urandom_range(1, 65535));
        1: typ = 16'($urandom_range(64, 65535));
        2: typ = ($urandom_range(1) == 1) ? 16'($urandom) : typ;
        default: begin
          if (pred.max_len != 32'hFFFF_FFFF)
            len = ($urandom_range(3) == 0 || pred.max_len > 32'hFFFF_0000) ?
                  32'hFFFF_FFFF : pred.max_len + 32'($urandom_range(1, 1000));
          else
            ver = ~ver;
        end
      endcase
      send_packet(typ, ver, len, $urandom);
    end else if (sel < 97) begin
      send_noise();
    end else begin
      // hold off until everything in flight is out
      drain_results();
    end
  endtask

  initial begin
    logic [31:0] max_pick;
    logic [63:0] mask_pick;
    pred            = new();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    sent_bytes      = 0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_VERSION;
    cfg_ch.data     = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // defaults: no type known, so every header is rejected
    send_packet(16'd0, 16'd1, 32'd0, 32'd0);
    send_packet(16'd5, 16'd2, 32'd0, 32'hFFFF_FFFF);
    drain_results();
    write_reg(REG_TYPE_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_MAX_LEN, 64'd4);
    write_reg(REG_VERSION, 64'hFFFF);
    write_reg(reg_idx_t'(2'd3), 64'd0);
    send_packet(16'd63, 16'hFFFF, 32'd0, 32'hFFFF_FFFF);
    send_packet(16'd0, 16'hFFFF, 32'd1, 32'd0);
    send_packet(16'd7, 16'hFFFF, 32'd4, 32'h1234_5678);
    send_packet(16'd64, 16'hFFFF, 32'd0, 32'hA5A5_5A5A);
    send_packet(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0F0F_F0F0);
    send_packet(16'd3, 16'h0000, 32'hFFFF_FFFF, 32'h8000_0001);
    send_packet(16'd3, 16'hFFFF, 32'd5, 32'h7FFF_FFFE);
    send_noise();
    drain_results();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      case (phase)
        0: max_pick = 32'd16;
        1: max_pick = 32'd0;
        2: max_pick = 32'hFFFF_FFFF;
        3: max_pick = MAX_LEN_RST;
        default: max_pick = $urandom_range(0, 24);
      endcase
      mask_pick = {$urandom, $urandom};
      if (phase == 0 || phase == 2) mask_pick = 64'hFFFF_FFFF_FFFF_FFFF;
      if (phase == 5) mask_pick = 64'd0;
      write_reg(REG_VERSION, (phase == 1) ? 64'h0000 :
                             (phase == 2) ? 64'hFFFF : 64'($urandom_range(0, 65535)));
      write_reg(REG_MAX_LEN, 64'(max_pick));
      write_reg(REG_TYPE_MASK, mask_pick);
      sent_bytes = 0;
      while (sent_bytes < 80) random_item();
      drain_results();
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pred.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pred.mismatch_count == 0 && pred.pending_results.size() == 0) begin
      $display("** length_prefixed_packet_deframer: PASSED **");
    end else begin
      if (pred.pending_results.size() != 0)
        $display("%0d expected results never arrived", pred.pending_results.size());
      $display("** length_prefixed_packet_deframer: FAILED **");
    end
    $finish;
  end
endmodule
